// File: design/rac_pkg.sv
`default_nettype none
// ============================================================================
// rac_pkg: shared definitions for the range add / count-at-least block
// Sizes, operation codes, the controller state type, the command that the
// controller broadcasts to the cell row, and the saturating adder.
// ============================================================================
package rac_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int BLOCK_SIZE   = 32;
    localparam int NUM_BLOCKS   = MAX_ELEMENTS / BLOCK_SIZE;

    localparam int IDX_W   = 10;                        // index field width
    localparam int OFS_W   = $clog2(BLOCK_SIZE);        // position inside a block
    localparam int BLK_W   = IDX_W - OFS_W;             // block number
    localparam int RED_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W   = 11;                        // match count and element count
    localparam int LOCAL_W = $clog2(BLOCK_SIZE + 1);    // count within one block
    localparam int VAL_W   = 32;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_COUNT = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_REDUCE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                    sweep;
        logic                    last;
        logic [1:0]              op;
        logic [IDX_W-1:0]        lo;
        logic [IDX_W-1:0]        hi;
        logic signed [VAL_W-1:0] val;
        logic [OFS_W-1:0]        pos;
    } cell_cmd_t;

    function automatic logic signed [VAL_W-1:0] sat_add(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic signed [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1]) begin
            sat_add = s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
            sat_add = s[VAL_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// File: design/rac_cell.sv
`default_nettype none
// ============================================================================
// rac_cell: one block of the element array
// Holds the stored values and the pending offset of one block, updates them
// one position per cycle during a sweep, counts hits, and adds its count to
// the running total handed along from the previous cell.
// ============================================================================
module rac_cell
    import rac_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cell_cmd_t        cmd,
    input  wire logic [BLK_W-1:0] cell_index,
    input  wire logic [CNT_W-1:0] sum_in,
    output logic [CNT_W-1:0]      sum_out
);

    logic signed [VAL_W-1:0] mem_reg [BLOCK_SIZE];
    logic signed [VAL_W-1:0] off_reg;
    logic [LOCAL_W-1:0]      local_reg;
    logic [CNT_W-1:0]        sum_reg;

    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] rd;
    logic signed [VAL_W:0]   total;
    logic signed [VAL_W:0]   thr;
    logic                    in_rng;
    logic                    whole;
    logic                    mine;
    logic                    hit;
    logic [LOCAL_W-1:0]      local_next;

    always_comb begin
        idx    = {cell_index, cmd.pos};
        rd     = mem_reg[cmd.pos];
        in_rng = (idx >= cmd.lo) && (idx <= cmd.hi);
        // A block strictly between the end blocks takes the amount as an offset.
        whole  = (cell_index > cmd.lo[IDX_W-1:OFS_W]) && (cell_index < cmd.hi[IDX_W-1:OFS_W]);
        mine   = (cell_index == cmd.lo[IDX_W-1:OFS_W]);
        // The comparison uses the exact sum, so it is one bit wider.
        total  = {rd[VAL_W-1], rd} + {off_reg[VAL_W-1], off_reg};
        thr    = {cmd.val[VAL_W-1], cmd.val};
        hit    = in_rng && (total >= thr);
        local_next = ((cmd.pos == '0) ? '0 : local_reg) + LOCAL_W'(hit);
    end

    always_ff @(posedge aclk) begin
        if (cmd.sweep) begin
            case (cmd.op)
                OP_LOAD: begin
                    // Loading folds the block's offset into every stored value.
                    if (mine) begin
                        mem_reg[cmd.pos] <= (cmd.pos == cmd.lo[OFS_W-1:0]) ?
                                            cmd.val : sat_add(rd, off_reg);
                    end
                end
                OP_ADD: begin
                    if (!whole && in_rng) begin
                        mem_reg[cmd.pos] <= sat_add(rd, cmd.val);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg   <= '0;
            local_reg <= '0;
        end else if (cmd.sweep) begin
            case (cmd.op)
                OP_LOAD: begin
                    if (mine && cmd.last) begin
                        off_reg <= '0;
                    end
                end
                OP_ADD: begin
                    if (whole && cmd.pos == '0) begin
                        off_reg <= sat_add(off_reg, cmd.val);
                    end
                end
                OP_COUNT: begin
                    local_reg <= local_next;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_in + CNT_W'(local_reg);
    end

    assign sum_out = sum_reg;

endmodule
`default_nettype wire

// File: design/range_add_count_at_least.sv
`default_nettype none
// ============================================================================
// range_add_count_at_least: blocked array with range add and range count
// A row of block cells sweeps all blocks in parallel, one position per cycle,
// and a chain through the cells sums the per-block match counts.
// ============================================================================
//
//  Channel   Direction  Signals                          Beat
//  s_        in         s_tvalid s_tready s_tdata s_tuser one operation
//  m_        out        m_tvalid m_tready m_tdata m_tuser one result
//  cfg_      in         cfg_valid cfg_ready cfg_data      element count write
//
//  Load and range add sweep over the positions of every block. Range count
//  does the sweep, then the ripple of the count chain through all cells.
//  Rejected ranges and unknown operations go from idle straight to finish.
//  Reset clears the block offsets and the element count; stored values are
//  undefined until loaded, and no clearing pass runs.
//  The result sits in an output register; a new beat is taken while it waits,
//  and the next result holds in the finish state until the register is free.
//
module range_add_count_at_least
    import rac_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [55:0]      s_tdata,   // lo_index[9:0], hi_index[19:10], operand_value[51:20]
    input  wire logic [1:0]       s_tuser,   // op[1:0]
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [15:0]           m_tdata,   // match_count[10:0]
    output logic [0:0]            m_tuser,   // range_error[0]
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CNT_W-1:0] cfg_data
);

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg;
    logic [1:0]              op_reg;
    logic [IDX_W-1:0]        lo_reg;
    logic [IDX_W-1:0]        hi_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic                    err_reg;
    logic [OFS_W-1:0]        pos_reg;
    logic [RED_W-1:0]        red_reg;
    logic                    out_valid_reg;
    logic [CNT_W-1:0]        out_count_reg;
    logic                    out_err_reg;

    logic [1:0]              in_op;
    logic [IDX_W-1:0]        in_lo;
    logic [IDX_W-1:0]        in_hi;
    logic                    in_err;
    logic                    in_known;
    logic                    accept;
    logic                    sweeping;
    logic                    out_free;
    logic                    finish;
    cell_cmd_t               cmd;
    logic [CNT_W-1:0]        chain [NUM_BLOCKS+1];

    assign in_op = s_tuser;
    assign in_lo = s_tdata[9:0];
    assign in_hi = s_tdata[19:10];

    always_comb begin
        in_known = (in_op == OP_LOAD) || (in_op == OP_ADD) || (in_op == OP_COUNT);
        if (in_op == OP_LOAD) begin
            in_err = {1'b0, in_lo} >= count_reg;
        end else if (in_known) begin
            in_err = (in_lo > in_hi) || ({1'b0, in_hi} >= count_reg);
        end else begin
            in_err = 1'b0;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (in_known && !in_err) ? ST_SWEEP : ST_FINISH;
                end
            end
            ST_SWEEP: begin
                if (pos_reg == OFS_W'(BLOCK_SIZE - 1)) begin
                    state_next = (op_reg == OP_COUNT) ? ST_REDUCE : ST_FINISH;
                end
            end
            ST_REDUCE: begin
                if (red_reg == RED_W'(NUM_BLOCKS - 1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs.
    always_comb begin
        out_free = !out_valid_reg || m_tready;
        s_tready = 1'b0;
        sweeping = 1'b0;
        finish   = 1'b0;
        case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_SWEEP:  sweeping = 1'b1;
            ST_FINISH: finish   = out_free;
            default: begin
            end
        endcase
        accept = s_tvalid && s_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                count_reg <= (cfg_data > CNT_W'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS) : cfg_data;
            end
            if (finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= in_op;
            lo_reg  <= in_lo;
            hi_reg  <= in_hi;
            val_reg <= s_tdata[51:20];
            err_reg <= in_err;
            pos_reg <= '0;
            red_reg <= '0;
        end else begin
            if (sweeping) begin
                pos_reg <= pos_reg + 1'b1;
            end
            if (state_reg == ST_REDUCE) begin
                red_reg <= red_reg + 1'b1;
            end
        end
        if (finish) begin
            out_count_reg <= (op_reg == OP_COUNT && !err_reg) ? chain[NUM_BLOCKS] : '0;
            out_err_reg   <= err_reg;
        end
    end

    always_comb begin
        cmd.sweep = sweeping;
        cmd.last  = (pos_reg == OFS_W'(BLOCK_SIZE - 1));
        cmd.op    = op_reg;
        cmd.lo    = lo_reg;
        cmd.hi    = hi_reg;
        cmd.val   = val_reg;
        cmd.pos   = pos_reg;
    end

    assign chain[0] = '0;

    for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
        rac_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .cell_index (BLK_W'(g)),
            .sum_in     (chain[g]),
            .sum_out    (chain[g+1])
        );
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(16-CNT_W){1'b0}}, out_count_reg};
    assign m_tuser   = out_err_reg;

`ifndef SYNTHESIS
    a_err_zero_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[CNT_W-1:0] == '0)
        else $error("range error with nonzero match count");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[CNT_W-1:0] <= CNT_W'(MAX_ELEMENTS))
        else $error("match count above element limit");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat taken while an operation is in progress");

    a_sweep_known_op: assert property (@(posedge aclk) disable iff (!aresetn)
        sweeping |-> !err_reg && (op_reg == OP_LOAD || op_reg == OP_ADD || op_reg == OP_COUNT))
        else $error("sweep started for a rejected operation");
`endif

endmodule
`default_nettype wire
